FILE: src/positional_list_engine_macros.svh
// Assertion helpers for the positional list engine.
// All checks run on aclk and are off while aresetn is low.
`ifndef POSITIONAL_LIST_ENGINE_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_MACROS_SVH

// Same-cycle implication
`define PLE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define PLE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/ple_pkg.sv
`timescale 1ns / 1ps

package ple_pkg;

    // Fixed port widths
    localparam int ACT_W  = 2;
    localparam int POS_W  = 6;
    localparam int VAL_W  = 32;
    localparam int STAT_W = 3;
    localparam int CNT_W  = 7;

    // Parameter defaults
    localparam int CAPACITY_DEF   = 16;
    localparam int VALUE_BITS_DEF = 32;

    // Request codes
    typedef enum logic [ACT_W-1:0] {
        ACT_INSERT     = 2'd0,
        ACT_REMOVE_AT  = 2'd1,
        ACT_REMOVE_VAL = 2'd2,
        ACT_LIST       = 2'd3
    } action_t;

    // Result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 3'd0,
        ST_FULL      = 3'd1,
        ST_BAD_POS   = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_NULL      = 3'd4,
        ST_EMPTY     = 3'd5
    } status_t;

    // Per-cycle command broadcast to every cell
    typedef enum logic [2:0] {
        OP_HOLD   = 3'd0,
        OP_INSERT = 3'd1,
        OP_DELETE = 3'd2,
        OP_ROTATE = 3'd3,
        OP_MATCH  = 3'd4
    } cell_op_t;

    typedef struct packed {
        cell_op_t           op;
        logic [CNT_W-1:0]   pos;   // target index
        logic [CNT_W-1:0]   cnt;   // live entry count
    } cell_ctl_t;

endpackage

FILE: src/positional_list_engine.sv
`timescale 1ns / 1ps
// Positional list engine: an ordered list of up to CAPACITY words held in a
// row of cells, one word per cell, with a live entry count.
// Input channel s_*: one request per item (insert at position, remove at
// position, remove first equal word, list all). Result channel m_*: status,
// element word/position, count after the request, and last on the final
// result of a request.
// Insert, remove at position and every refused request but a missing word
// give their result in the output register the cycle after acceptance.
// Remove by word first has all cells compare in parallel, then closes up
// the first match by a one-step shift. Listing rotates the row one cell per
// cycle while the output register is free, past cell 0, which feeds the
// output, and ends back in its original order. One request is in work
// at a time; the next is taken once the output register is free or drains.
// When the receiver stalls, the result holds in the output register and the
// row holds its contents. Reset empties the list (count zero) and drops any
// pending result; cell contents need no clearing.
module positional_list_engine #(
    parameter int CAPACITY   = ple_pkg::CAPACITY_DEF,
    parameter int VALUE_BITS = ple_pkg::VALUE_BITS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,

    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [ple_pkg::ACT_W-1:0]  s_action,
    input  logic [ple_pkg::POS_W-1:0]  s_position,
    input  logic [ple_pkg::VAL_W-1:0]  s_value,

    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [ple_pkg::STAT_W-1:0] m_status,
    output logic [ple_pkg::VAL_W-1:0]  m_element_value,
    output logic [ple_pkg::POS_W-1:0]  m_element_position,
    output logic [ple_pkg::CNT_W-1:0]  m_count,
    output logic                       m_last
);
    import ple_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_FIND = 3'b010,
        S_LIST = 3'b100
    } state_t;

    state_t          state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [CW-1:0]   list_idx_reg, list_idx_next;

    logic              m_valid_reg, m_valid_next;
    logic [STAT_W-1:0] m_status_reg, m_status_next;
    logic [VAL_W-1:0]  m_value_reg, m_value_next;
    logic [POS_W-1:0]  m_pos_reg, m_pos_next;
    logic [CNT_W-1:0]  m_count_reg, m_count_next;
    logic              m_last_reg, m_last_next;

    cell_ctl_t             cell_ctl;
    logic [VALUE_BITS-1:0] cell_data [CAPACITY];
    logic [CAPACITY-1:0]   cell_match;

    logic [VALUE_BITS-1:0] in_word;
    logic                  in_null;
    logic [CNT_W-1:0]      in_pos;
    logic [CNT_W-1:0]      cnt_ext;
    logic [CNT_W-1:0]      ins_pos;
    logic                  full;
    logic                  out_free;
    logic                  accept;
    logic                  hit_found;
    logic [IW-1:0]         hit_idx;
    logic [CW-1:0]         list_idx_p1;

    // Request decode helpers
    assign in_word     = VALUE_BITS'(s_value);
    assign in_null     = (in_word == '0);
    assign in_pos      = CNT_W'(s_position);
    assign cnt_ext     = CNT_W'(count_reg);
    assign ins_pos     = (in_pos > cnt_ext) ? cnt_ext : in_pos;
    assign full        = (count_reg == CW'(CAPACITY));
    assign out_free    = !m_valid_reg || m_ready;
    assign s_ready     = (state_reg == S_IDLE) && out_free;
    assign accept      = s_valid && s_ready;
    assign list_idx_p1 = list_idx_reg + 1'b1;

    // Row of cells
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        ple_cell #(
            .VALUE_BITS (VALUE_BITS),
            .INDEX      (g)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctl     (cell_ctl),
            .wdata   (in_word),
            .head    (cell_data[0]),
            .left    (cell_data[(g == 0) ? 0 : g - 1]),
            .right   (cell_data[(g == CAPACITY - 1) ? g : g + 1]),
            .data    (cell_data[g]),
            .match   (cell_match[g])
        );
    end

    // First matching cell
    always_comb begin
        hit_found = 1'b0;
        hit_idx   = '0;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (cell_match[i]) begin
                hit_found = 1'b1;
                hit_idx   = IW'(i);
            end
        end
    end

    // Sequencer and result build
    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        list_idx_next = list_idx_reg;
        cell_ctl.op   = OP_HOLD;
        cell_ctl.pos  = '0;
        cell_ctl.cnt  = cnt_ext;

        m_valid_next  = m_valid_reg && !m_ready;
        m_status_next = m_status_reg;
        m_value_next  = m_value_reg;
        m_pos_next    = m_pos_reg;
        m_count_next  = m_count_reg;
        m_last_next   = m_last_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    m_status_next = ST_OK;
                    m_value_next  = '0;
                    m_pos_next    = '0;
                    m_count_next  = cnt_ext;
                    m_last_next   = 1'b1;
                    unique case (action_t'(s_action))
                        ACT_INSERT: begin
                            m_valid_next = 1'b1;
                            if (in_null) begin
                                m_status_next = ST_NULL;
                            end else if (full) begin
                                m_status_next = ST_FULL;
                            end else begin
                                cell_ctl.op  = OP_INSERT;
                                cell_ctl.pos = ins_pos;
                                count_next   = count_reg + 1'b1;
                                m_pos_next   = POS_W'(ins_pos);
                                m_count_next = CNT_W'(count_next);
                            end
                        end
                        ACT_REMOVE_AT: begin
                            m_valid_next = 1'b1;
                            if (in_pos >= cnt_ext) begin
                                m_status_next = ST_BAD_POS;
                            end else begin
                                cell_ctl.op  = OP_DELETE;
                                cell_ctl.pos = in_pos;
                                count_next   = count_reg - 1'b1;
                                m_pos_next   = s_position;
                                m_count_next = CNT_W'(count_next);
                            end
                        end
                        ACT_REMOVE_VAL: begin
                            if (in_null) begin
                                m_valid_next  = 1'b1;
                                m_status_next = ST_NULL;
                            end else begin
                                cell_ctl.op = OP_MATCH;
                                state_next  = S_FIND;
                            end
                        end
                        ACT_LIST: begin
                            if (count_reg == '0) begin
                                m_valid_next  = 1'b1;
                                m_status_next = ST_EMPTY;
                            end else begin
                                list_idx_next = '0;
                                state_next    = S_LIST;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_FIND: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_value_next = '0;
                    m_last_next  = 1'b1;
                    state_next   = S_IDLE;
                    if (hit_found) begin
                        cell_ctl.op   = OP_DELETE;
                        cell_ctl.pos  = CNT_W'(hit_idx);
                        count_next    = count_reg - 1'b1;
                        m_status_next = ST_OK;
                        m_pos_next    = POS_W'(hit_idx);
                        m_count_next  = CNT_W'(count_next);
                    end else begin
                        m_status_next = ST_NOT_FOUND;
                        m_pos_next    = '0;
                        m_count_next  = cnt_ext;
                    end
                end
            end
            S_LIST: begin
                if (out_free) begin
                    cell_ctl.op   = OP_ROTATE;
                    m_valid_next  = 1'b1;
                    m_status_next = ST_OK;
                    m_value_next  = VAL_W'(cell_data[0]);
                    m_pos_next    = POS_W'(list_idx_reg);
                    m_count_next  = cnt_ext;
                    m_last_next   = (list_idx_p1 == count_reg);
                    list_idx_next = list_idx_p1;
                    if (list_idx_p1 == count_reg) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            list_idx_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            list_idx_reg <= list_idx_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        m_status_reg <= m_status_next;
        m_value_reg  <= m_value_next;
        m_pos_reg    <= m_pos_next;
        m_count_reg  <= m_count_next;
        m_last_reg   <= m_last_next;
    end

    assign m_valid            = m_valid_reg;
    assign m_status           = m_status_reg;
    assign m_element_value    = m_value_reg;
    assign m_element_position = m_pos_reg;
    assign m_count            = m_count_reg;
    assign m_last             = m_last_reg;

    // Checks
    `include "positional_list_engine_macros.svh"

    `PLE_ASSERT_NOW(a_count_cap, 1'b1, count_reg <= CW'(CAPACITY), "count above capacity")
    `PLE_ASSERT_NOW(a_list_idx, state_reg == S_LIST, list_idx_reg < count_reg, "list index past count")
    `PLE_ASSERT_NEXT(a_single_result, accept && (s_action == ACT_INSERT || s_action == ACT_REMOVE_AT), m_valid && m_last && state_reg == S_IDLE, "missing single result")

endmodule

FILE: src/ple_cell.sv
`timescale 1ns / 1ps

module ple_cell #(
    parameter int VALUE_BITS = ple_pkg::VALUE_BITS_DEF,
    parameter int INDEX      = 0
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  ple_pkg::cell_ctl_t    ctl,
    input  logic [VALUE_BITS-1:0] wdata,
    input  logic [VALUE_BITS-1:0] head,
    input  logic [VALUE_BITS-1:0] left,
    input  logic [VALUE_BITS-1:0] right,
    output logic [VALUE_BITS-1:0] data,
    output logic                  match
);
    import ple_pkg::*;

    localparam logic [CNT_W-1:0] IDX    = CNT_W'(INDEX);
    localparam logic [CNT_W-1:0] IDX_P1 = CNT_W'(INDEX + 1);

    logic [VALUE_BITS-1:0] data_reg, data_next;
    logic                  match_reg, match_next;

    // Word update: open a gap, close a gap, or rotate one step toward cell 0; a match op sets the match flag
    always_comb begin
        data_next  = data_reg;
        match_next = match_reg;
        unique case (ctl.op)
            OP_INSERT: begin
                if (IDX > ctl.pos) begin
                    data_next = left;
                end else if (IDX == ctl.pos) begin
                    data_next = wdata;
                end
            end
            OP_DELETE: begin
                if (IDX >= ctl.pos) begin
                    data_next = right;
                end
            end
            OP_ROTATE: begin
                if (IDX_P1 == ctl.cnt) begin
                    data_next = head;
                end else if (IDX_P1 < ctl.cnt) begin
                    data_next = right;
                end
            end
            OP_MATCH: begin
                match_next = (IDX < ctl.cnt) && (data_reg == wdata);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            match_reg <= 1'b0;
        end else begin
            match_reg <= match_next;
        end
    end

    assign data  = data_reg;
    assign match = match_reg;

endmodule

FILE: test/positional_list_engine_tb.sv
`timescale 1ns / 1ps

module positional_list_engine_tb;
    import ple_pkg::*;

    localparam int CAPACITY = CAPACITY_DEF;

    // One result word as seen on the m_ channel
    typedef struct {
        status_t          st;
        logic [VAL_W-1:0] val;
        logic [POS_W-1:0] pos;
        logic [CNT_W-1:0] cnt;
        logic             last;
    } list_result_t;

    // Shadow list plus the queue of results it predicts
    class list_scoreboard;
        logic [VAL_W-1:0] slots [CAPACITY];
        int               entries;
        list_result_t     expected_q [$];
        int               mismatches;

        function new();
            entries    = 0;
            mismatches = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void push(status_t st, logic [VAL_W-1:0] val, int pos, int cnt, bit last);
            list_result_t r;
            r.st   = st;
            r.val  = val;
            r.pos  = POS_W'(pos);
            r.cnt  = CNT_W'(cnt);
            r.last = last;
            expected_q.push_back(r);
        endfunction

        // Close the hole left by a removed entry
        function void close_gap(int idx);
            for (int i = idx; i + 1 < entries; i++)
                slots[i] = slots[i + 1];
            entries--;
        endfunction

        // Update the shadow list for one accepted request
        function void note_request(action_t act, logic [POS_W-1:0] pos, logic [VAL_W-1:0] v);
            int p;
            int hit;
            case (act)
                ACT_INSERT: begin
                    if (v == '0) begin
                        push(ST_NULL, '0, 0, entries, 1'b1);
                    end else if (entries >= CAPACITY) begin
                        push(ST_FULL, '0, 0, entries, 1'b1);
                    end else begin
                        p = (pos > entries) ? entries : pos;
                        for (int i = entries; i > p; i--)
                            slots[i] = slots[i - 1];
                        slots[p] = v;
                        entries++;
                        push(ST_OK, '0, p, entries, 1'b1);
                    end
                end
                ACT_REMOVE_AT: begin
                    if (pos >= entries) begin
                        push(ST_BAD_POS, '0, 0, entries, 1'b1);
                    end else begin
                        close_gap(pos);
                        push(ST_OK, '0, pos, entries, 1'b1);
                    end
                end
                ACT_REMOVE_VAL: begin
                    if (v == '0) begin
                        push(ST_NULL, '0, 0, entries, 1'b1);
                    end else begin
                        hit = -1;
                        for (int i = 0; i < entries; i++)
                            if (hit < 0 && slots[i] == v)
                                hit = i;
                        if (hit < 0) begin
                            push(ST_NOT_FOUND, '0, 0, entries, 1'b1);
                        end else begin
                            close_gap(hit);
                            push(ST_OK, '0, hit, entries, 1'b1);
                        end
                    end
                end
                default: begin
                    if (entries == 0)
                        push(ST_EMPTY, '0, 0, 0, 1'b1);
                    else
                        for (int i = 0; i < entries; i++)
                            push(ST_OK, slots[i], i, entries, i == entries - 1);
                end
            endcase
        endfunction

        // Compare one accepted result with the oldest prediction
        function void check_result(logic [STAT_W-1:0] st, logic [VAL_W-1:0] val,
                                   logic [POS_W-1:0] pos, logic [CNT_W-1:0] cnt,
                                   logic last);
            list_result_t e;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: status %0d value %h pos %0d count %0d last %0b",
                             st, val, pos, cnt, last);
                return;
            end
            e = expected_q.pop_front();
            if (e.st !== st || e.val !== val || e.pos !== pos || e.cnt !== cnt
                    || e.last !== last) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("result mismatch (exp/act): status %0d/%0d value %h/%h",
                             e.st, st, e.val, val);
                    $display("    pos %0d/%0d count %0d/%0d last %0b/%0b",
                             e.pos, pos, e.cnt, cnt, e.last, last);
                end
            end
        endfunction
    endclass

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [ACT_W-1:0]   s_action = ACT_INSERT;
    logic [POS_W-1:0]   s_position = '0;
    logic [VAL_W-1:0]   s_value = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [STAT_W-1:0]  m_status;
    logic [VAL_W-1:0]   m_element_value;
    logic [POS_W-1:0]   m_element_position;
    logic [CNT_W-1:0]   m_count;
    logic               m_last;

    bit                 steady = 1'b0;
    bit                 growing = 1'b1;
    list_scoreboard     sb = new();

    logic [VAL_W-1:0]   value_pool [8] = '{32'h0000_0001, 32'hFFFF_FFFF, 32'h8000_0000,
                                           32'h7FFF_FFFF, 32'h1234_5678, 32'hDEAD_BEEF,
                                           32'h0000_00A5, 32'h5A5A_5A5A};

    positional_list_engine dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_action           (s_action),
        .s_position         (s_position),
        .s_value            (s_value),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_status           (m_status),
        .m_element_value    (m_element_value),
        .m_element_position (m_element_position),
        .m_count            (m_count),
        .m_last             (m_last)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Receiver stalls with a chance of about 23 in 100, except in the steady stretch
    always @(posedge aclk) begin
        m_ready <= steady || ($urandom_range(99) >= 23);
    end

    // Result monitor
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_status, m_element_value, m_element_position, m_count, m_last);
    end

    // Present one request and hold it until accepted
    task automatic send_request(action_t act, logic [POS_W-1:0] pos, logic [VAL_W-1:0] v);
        if (!steady && $urandom_range(99) < 20) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_action   <= act;
        s_position <= pos;
        s_value    <= v;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(act, pos, v);
    endtask

    // Hold off the sender until every predicted result has come back
    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
    endtask

    // Random request, biased toward filling or emptying the list
    task automatic random_request();
        int               roll;
        int               n;
        action_t          act;
        logic [POS_W-1:0] pos;
        logic [VAL_W-1:0] v;
        n = sb.entries;
        if (n >= CAPACITY)
            growing = 1'b0;
        else if (n == 0)
            growing = 1'b1;
        roll = $urandom_range(99);
        if (growing) begin
            if (roll < 60)      act = ACT_INSERT;
            else if (roll < 72) act = ACT_REMOVE_AT;
            else if (roll < 84) act = ACT_REMOVE_VAL;
            else                act = ACT_LIST;
        end else begin
            if (roll < 20)      act = ACT_INSERT;
            else if (roll < 50) act = ACT_REMOVE_AT;
            else if (roll < 80) act = ACT_REMOVE_VAL;
            else                act = ACT_LIST;
        end
        if ($urandom_range(9) == 0)
            pos = POS_W'($urandom_range(63));
        else
            pos = POS_W'($urandom_range(n));
        roll = $urandom_range(99);
        if (roll < 5)
            v = '0;
        else if (roll < 15)
            v = $urandom;
        else if (act == ACT_REMOVE_VAL && n > 0 && roll >= 40)
            v = sb.slots[$urandom_range(n - 1)];
        else
            v = value_pool[$urandom_range(7)];
        send_request(act, pos, v);
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Refusals on an empty list
        send_request(ACT_LIST, 6'd0, '0);
        send_request(ACT_REMOVE_AT, 6'd0, '0);
        send_request(ACT_REMOVE_VAL, 6'd5, 32'h0000_0005);
        send_request(ACT_REMOVE_VAL, 6'd0, '0);
        send_request(ACT_INSERT, 6'd0, '0);

        // Append past the end, insert at head and middle, fill up, then insert into the full list
        send_request(ACT_INSERT, 6'd63, 32'hFFFF_FFFF);
        send_request(ACT_INSERT, 6'd0, 32'h0000_0001);
        send_request(ACT_INSERT, 6'd1, 32'h8000_0000);
        send_request(ACT_INSERT, 6'd0, 32'h7FFF_FFFF);
        for (int i = 0; i < CAPACITY - 4; i++)
            send_request(ACT_INSERT, 6'($urandom_range(sb.entries)),
                         (i % 3 == 0) ? 32'h0000_0001 : 32'($urandom));
        send_request(ACT_INSERT, 6'd3, 32'h0000_0042);

        // Full listing, removals at both ends, first-equal removal, bad index
        send_request(ACT_LIST, 6'd0, '0);
        send_request(ACT_REMOVE_AT, 6'(CAPACITY - 1), '0);
        send_request(ACT_REMOVE_AT, 6'd0, '0);
        send_request(ACT_REMOVE_VAL, 6'd0, 32'h0000_0001);
        send_request(ACT_REMOVE_AT, 6'd63, '0);
        drain_results();

        for (int k = 0; k < 350; k++) begin
            steady = (k >= 100 && k < 180);
            if (k == 175)
                drain_results();
            random_request();
        end
        s_valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: files.f
+incdir+src
src/ple_pkg.sv
src/ple_cell.sv
src/positional_list_engine.sv
test/positional_list_engine_tb.sv
